// ===== hw/rtl/tdpd_pkg.sv =====
`default_nettype none

package tdpd_pkg;

  localparam int DATA_BYTE_W = 8;
  localparam int SAMPLE_W    = 32;
  localparam int CHAN_IDX_W  = 4;

  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 12;
  localparam int SPC_W       = 12;
  localparam int CC_W        = 5;

  localparam logic [SPC_W-1:0] SPC_RESET = 12'd100;
  localparam logic [CC_W-1:0]  CC_RESET  = 5'd1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SAMPLES_PER_CHANNEL = 1'b0,
    REG_CHANNEL_COUNT       = 1'b1
  } cfg_reg_t;

  // tag type nibble
  localparam logic [3:0] TAG_D4  = 4'h1;
  localparam logic [3:0] TAG_D8  = 4'h2;
  localparam logic [3:0] TAG_D12 = 4'h3;
  localparam logic [3:0] TAG_D16 = 4'h4;

  typedef enum logic [2:0] {
    BT_ABS = 3'd0,
    BT_D4  = 3'd1,
    BT_D8  = 3'd2,
    BT_D12 = 3'd3,
    BT_D16 = 3'd4
  } blk_t;

  typedef enum logic [4:0] {
    PH_WAIT  = 5'b00001,
    PH_FIRST = 5'b00010,
    PH_TAG   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [CHAN_IDX_W-1:0]      channel_index;
    logic                       run_last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdpd_if.sv =====
`default_nettype none

interface tdpd_in_if import tdpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [DATA_BYTE_W-1:0] data_byte;
  logic                   packet_start;

  modport source (output valid, output data_byte, output packet_start, input ready);
  modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface

interface tdpd_out_if import tdpd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [CHAN_IDX_W-1:0]      channel_index;
  logic                       run_last;

  modport source (output valid, output sample_value, output channel_index, output run_last,
                  input ready);
  modport sink   (input valid, input sample_value, input channel_index, input run_last,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tagged_delta_packet_decoder_core.sv =====
// channel  dir  handshake       payload
// in_bus   in   valid/ready     data_byte[7:0], packet_start
// out_bus  out  valid/ready     sample_value[31:0] signed, channel_index[3:0], run_last
// cfg      in   cfg_wr_en       cfg_addr[0], cfg_wdata[11:0]
//
// a byte is registered, decoded combinationally and its samples land in a two-entry result buffer
// the first sample passes the input register and then the result buffer before out_bus shows it
// one byte per cycle while out_ready is high and each byte gives at most one sample; a byte
// of two 4-bit differences waits until the result buffer drains, one beat per cycle
// rst_n is synchronous; out_ready low fills the buffer, then the input register holds

`default_nettype none

module tagged_delta_packet_decoder_core import tdpd_pkg::*; #(
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_SAMPLES  = 4095
) (
  input  wire                   clk,
  input  wire                   rst_n,
  tdpd_in_if.sink               in_bus,
  tdpd_out_if.source            out_bus,
  input  wire                   cfg_wr_en,
  input  wire [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW  = $clog2(MAX_CHANNELS + 1);
  localparam int SW  = $clog2(MAX_SAMPLES + 1);
  localparam int CHW = (CW > CC_W) ? CW : CC_W;
  localparam int SPW = (SW > SPC_W) ? SW : SPC_W;

  // configuration
  logic [SPC_W-1:0] spc_r;
  logic [CC_W-1:0]  cc_r;
  logic [CHW-1:0]   eff_ch;
  logic [SPW-1:0]   eff_spc;

  // input register
  logic                   s1_v_r;
  logic [DATA_BYTE_W-1:0] s1_byte_r;
  logic                   s1_start_r;

  // parser state
  phase_t         ph_r,   ph_nxt;
  logic           par_r,  par_nxt;
  logic [31:0]    gat_r,  gat_nxt;
  logic [1:0]     gc_r,   gc_nxt;
  logic [31:0]    run_r,  run_nxt;
  blk_t           bt_r,   bt_nxt;
  logic [7:0]     brem_r, brem_nxt;
  logic [SW-1:0]  csd_r,  csd_nxt;
  logic [CW-1:0]  cur_r,  cur_nxt;

  // decode temporaries
  logic [7:0]     b;
  logic [15:0]    tag;
  logic [11:0]    d12;
  logic [15:0]    d16;
  logic           active;
  logic           after_blk;
  logic [1:0]     emit_cnt;
  logic [31:0]    emit_val0;
  logic [31:0]    emit_val1;
  logic [CW+3:0]  ch_wide;
  res_t           res0;
  res_t           res1;
  logic           proc;

  // result buffer
  res_t       slot_r [2];
  res_t       slot_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  function automatic logic [SW-1:0] sat_inc(input logic [SW-1:0] v);
    return (v < SW'(MAX_SAMPLES)) ? v + SW'(1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r <= SPC_RESET;
      cc_r  <= CC_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SAMPLES_PER_CHANNEL: spc_r <= cfg_wdata[SPC_W-1:0];
        REG_CHANNEL_COUNT:       cc_r  <= cfg_wdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_ch  = (CHW'(cc_r) > CHW'(MAX_CHANNELS)) ? CHW'(MAX_CHANNELS) : CHW'(cc_r);
  assign eff_spc = (SPW'(spc_r) > SPW'(MAX_SAMPLES)) ? SPW'(MAX_SAMPLES) : SPW'(spc_r);

  // input register
  assign in_bus.ready = rst_n && (!s1_v_r || proc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      s1_v_r <= 1'b1;
    end else if (proc) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_byte_r  <= in_bus.data_byte;
      s1_start_r <= in_bus.packet_start;
    end
  end

  // one-byte decode
  always_comb begin
    ph_nxt    = ph_r;
    par_nxt   = par_r;
    gat_nxt   = gat_r;
    gc_nxt    = gc_r;
    run_nxt   = run_r;
    bt_nxt    = bt_r;
    brem_nxt  = brem_r;
    csd_nxt   = csd_r;
    cur_nxt   = cur_r;
    b         = s1_byte_r;
    tag       = {gat_r[7:0], s1_byte_r};
    d12       = '0;
    d16       = '0;
    active    = 1'b0;
    after_blk = 1'b0;
    emit_cnt  = 2'd0;
    emit_val0 = '0;
    emit_val1 = '0;

    if (s1_start_r) begin
      par_nxt  = 1'b0;
      cur_nxt  = '0;
      run_nxt  = '0;
      bt_nxt   = BT_ABS;
      brem_nxt = '0;
      gc_nxt   = '0;
      gat_nxt  = '0;
      csd_nxt  = '0;
      ph_nxt   = (eff_ch == '0) ? PH_DONE : PH_FIRST;
    end
    ch_wide = {4'b0, cur_nxt};

    case (ph_nxt)
      PH_FIRST: begin
        active = 1'b1;
        if (!(gc_nxt == 2'd0 && par_nxt)) begin
          gat_nxt = {gat_nxt[23:0], b};
          if (gc_nxt == 2'd3) begin
            run_nxt   = gat_nxt;
            csd_nxt   = sat_inc('0);
            emit_cnt  = 2'd1;
            emit_val0 = run_nxt;
            after_blk = 1'b1;
          end else begin
            gc_nxt = gc_nxt + 2'd1;
          end
        end
      end
      PH_TAG: begin
        active = 1'b1;
        if (!(gc_nxt == 2'd0 && par_nxt)) begin
          if (gc_nxt == 2'd0) begin
            gat_nxt = {24'b0, b};
            gc_nxt  = 2'd1;
          end else begin
            case (tag[15:12])
              TAG_D4:  bt_nxt = BT_D4;
              TAG_D8:  bt_nxt = BT_D8;
              TAG_D12: bt_nxt = BT_D12;
              TAG_D16: bt_nxt = BT_D16;
              default: bt_nxt = BT_ABS;
            endcase
            brem_nxt = tag[7:0];
            gc_nxt   = '0;
            gat_nxt  = '0;
            if (tag[7:0] == 8'd0) begin
              after_blk = 1'b1;
            end else begin
              ph_nxt = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        active = 1'b1;
        case (bt_nxt)
          BT_D4: begin
            run_nxt = run_nxt - {{28{b[7]}}, b[7:4]};
            if (brem_nxt != 8'd0) brem_nxt = brem_nxt - 8'd1;
            csd_nxt   = sat_inc(csd_nxt);
            emit_cnt  = 2'd1;
            emit_val0 = run_nxt;
            if (brem_nxt != 8'd0) begin
              run_nxt   = run_nxt - {{28{b[3]}}, b[3:0]};
              brem_nxt  = brem_nxt - 8'd1;
              csd_nxt   = sat_inc(csd_nxt);
              emit_cnt  = 2'd2;
              emit_val1 = run_nxt;
            end
          end
          BT_D8: begin
            run_nxt = run_nxt - {{24{b[7]}}, b};
            if (brem_nxt != 8'd0) brem_nxt = brem_nxt - 8'd1;
            csd_nxt   = sat_inc(csd_nxt);
            emit_cnt  = 2'd1;
            emit_val0 = run_nxt;
          end
          BT_D12: begin
            if (gc_nxt == 2'd0) begin
              gat_nxt = {24'b0, b};
              gc_nxt  = 2'd1;
            end else begin
              if (gc_nxt == 2'd1) begin
                d12 = {gat_nxt[7:0], b[7:4]};
              end else begin
                d12 = {gat_nxt[3:0], b};
              end
              run_nxt = run_nxt - {{20{d12[11]}}, d12};
              if (brem_nxt != 8'd0) brem_nxt = brem_nxt - 8'd1;
              csd_nxt   = sat_inc(csd_nxt);
              emit_cnt  = 2'd1;
              emit_val0 = run_nxt;
              if (gc_nxt == 2'd1) begin
                gat_nxt = {28'b0, b[3:0]};
                gc_nxt  = (brem_nxt != 8'd0) ? 2'd2 : 2'd0;
              end else begin
                gc_nxt = 2'd0;
              end
            end
          end
          BT_D16: begin
            if (gc_nxt == 2'd0) begin
              gat_nxt = {24'b0, b};
              gc_nxt  = 2'd1;
            end else begin
              d16     = {gat_nxt[7:0], b};
              run_nxt = run_nxt - {{16{d16[15]}}, d16};
              if (brem_nxt != 8'd0) brem_nxt = brem_nxt - 8'd1;
              csd_nxt   = sat_inc(csd_nxt);
              emit_cnt  = 2'd1;
              emit_val0 = run_nxt;
              gc_nxt    = 2'd0;
            end
          end
          default: begin
            gat_nxt = {gat_nxt[23:0], b};
            if (gc_nxt == 2'd2) begin
              run_nxt = {{8{gat_nxt[23]}}, gat_nxt[23:0]};
              if (brem_nxt != 8'd0) brem_nxt = brem_nxt - 8'd1;
              csd_nxt   = sat_inc(csd_nxt);
              emit_cnt  = 2'd1;
              emit_val0 = run_nxt;
              gc_nxt    = 2'd0;
            end else begin
              gc_nxt = gc_nxt + 2'd1;
            end
          end
        endcase
        if (brem_nxt == 8'd0) after_blk = 1'b1;
      end
      default: ;
    endcase

    // end of block or first sample: next tag or next channel
    if (after_blk) begin
      gc_nxt = '0;
      if (SPW'(csd_nxt) >= eff_spc) begin
        cur_nxt = cur_nxt + CW'(1);
        gat_nxt = '0;
        csd_nxt = '0;
        ph_nxt  = (CHW'(cur_nxt) >= eff_ch) ? PH_DONE : PH_FIRST;
      end else begin
        ph_nxt = PH_TAG;
      end
    end

    if (active) par_nxt = !par_nxt;

    res0.sample_value  = emit_val0;
    res0.channel_index = ch_wide[3:0];
    res0.run_last      = (emit_cnt == 2'd1);
    res1.sample_value  = emit_val1;
    res1.channel_index = ch_wide[3:0];
    res1.run_last      = 1'b1;
  end

  assign proc = s1_v_r &&
                (({1'b0, cnt_r} - {2'b0, pop} + {1'b0, emit_cnt}) <= 3'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_WAIT;
      par_r  <= 1'b0;
      gat_r  <= '0;
      gc_r   <= '0;
      run_r  <= '0;
      bt_r   <= BT_ABS;
      brem_r <= '0;
      csd_r  <= '0;
      cur_r  <= '0;
    end else if (proc) begin
      ph_r   <= ph_nxt;
      par_r  <= par_nxt;
      gat_r  <= gat_nxt;
      gc_r   <= gc_nxt;
      run_r  <= run_nxt;
      bt_r   <= bt_nxt;
      brem_r <= brem_nxt;
      csd_r  <= csd_nxt;
      cur_r  <= cur_nxt;
    end
  end

  // result buffer
  assign pop = (cnt_r != 2'd0) && out_bus.ready;

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (pop) begin
      slot_nxt[0] = slot_r[1];
      cnt_nxt     = cnt_r - 2'd1;
    end
    if (proc) begin
      if (emit_cnt == 2'd1) begin
        slot_nxt[cnt_nxt[0]] = res0;
        cnt_nxt              = cnt_nxt + 2'd1;
      end else if (emit_cnt == 2'd2) begin
        slot_nxt[0] = res0;
        slot_nxt[1] = res1;
        cnt_nxt     = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign out_bus.valid         = (cnt_r != 2'd0);
  assign out_bus.sample_value  = slot_r[0].sample_value;
  assign out_bus.channel_index = slot_r[0].channel_index;
  assign out_bus.run_last      = slot_r[0].run_last;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.run_last |-> cnt_r == 2'd2)
    else $error("first of a sample pair shown without its partner");

  a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CHW'(cur_r) <= CHW'(MAX_CHANNELS))
    else $error("channel counter past limit");

  a_samp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SPW'(csd_r) <= SPW'(MAX_SAMPLES))
    else $error("sample counter past saturation");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
  import tdpd_pkg::*;

  localparam int          LANE_LIMIT    = 16;
  localparam logic [11:0] COUNT_CEIL    = 12'd4095;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = 20;
  localparam int          NO_CUT        = 32'h7fffffff;
  localparam int          ITEM_TARGET   = 340;

  // first sample, 4-bit run with dropped nibble, odd 12-bit run, 8-bit, 16-bit,
  // empty tag and one absolute sample, with pad bytes at odd offsets
  localparam logic [7:0] OPENING_PKT [31] = '{
    8'h80, 8'h00, 8'h00, 8'h00,
    8'h10, 8'h03, 8'h7f, 8'h80,
    8'h30, 8'h03, 8'h80, 8'h0f, 8'hff, 8'h12, 8'h30, 8'ha5,
    8'h20, 8'h01, 8'h80, 8'h5a,
    8'h40, 8'h01, 8'h7f, 8'hff,
    8'hf0, 8'h00,
    8'h00, 8'h01, 8'hff, 8'hff, 8'hff
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tdpd_in_if  in_bus ();
  tdpd_out_if out_bus ();

  tagged_delta_packet_decoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // decoder state as seen from the byte stream
  logic [11:0] spc_setting  = SPC_RESET;
  logic [4:0]  chan_setting = CC_RESET;
  phase_t      phase        = PH_WAIT;
  logic        odd_offset   = 1'b0;
  logic [31:0] gather       = '0;
  logic [1:0]  gather_cnt   = '0;
  logic [31:0] running      = '0;
  blk_t        blk          = BT_ABS;
  logic [7:0]  blk_left     = '0;
  logic [11:0] chan_done    = '0;
  logic [4:0]  chan_idx     = '0;

  res_t        beat_buf [2];
  int          beat_cnt;
  res_t        pending_samples [$];
  res_t        want_beat;

  int          mismatches = 0;
  int          items_sent = 0;
  bit          no_idle    = 1'b0;
  int          pkt_off;
  int          pkt_cut;

  function automatic logic [31:0] sext(input logic [31:0] v, input int bits);
    logic [31:0] m;
    logic [31:0] mask;
    m    = 32'd1 << (bits - 1);
    mask = (m << 1) - 32'd1;
    return ((v & mask) ^ m) - m;
  endfunction

  function automatic int active_chans();
    return (chan_setting > LANE_LIMIT) ? LANE_LIMIT : int'(chan_setting);
  endfunction

  function automatic void open_channel();
    gather_cnt = '0;
    gather     = '0;
    chan_done  = '0;
    phase      = (chan_idx >= active_chans()) ? PH_DONE : PH_FIRST;
  endfunction

  function automatic void close_block();
    gather_cnt = '0;
    if (chan_done >= spc_setting) begin
      chan_idx++;
      open_channel();
    end else begin
      phase = PH_TAG;
    end
  endfunction

  function automatic void add_sample(input logic [31:0] v);
    beat_buf[beat_cnt].sample_value  = v;
    beat_buf[beat_cnt].channel_index = chan_idx[3:0];
    beat_buf[beat_cnt].run_last      = 1'b0;
    beat_cnt++;
    if (chan_done < COUNT_CEIL)
      chan_done++;
  endfunction

  function automatic void apply_diff(input logic [31:0] d);
    running = running - d;
    if (blk_left != 0)
      blk_left--;
    add_sample(running);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic st);
    logic [15:0] tag;
    beat_cnt = 0;
    if (st) begin
      odd_offset = 1'b0;
      chan_idx   = '0;
      running    = '0;
      blk        = BT_ABS;
      blk_left   = '0;
      open_channel();
    end
    if (phase == PH_FIRST || phase == PH_TAG || phase == PH_DATA) begin
      if (phase == PH_FIRST) begin
        if (!(gather_cnt == 0 && odd_offset)) begin
          gather = {gather[23:0], b};
          if (gather_cnt == 2'd3) begin
            running   = gather;
            chan_done = '0;
            add_sample(running);
            close_block();
          end else begin
            gather_cnt++;
          end
        end
      end else if (phase == PH_TAG) begin
        if (!(gather_cnt == 0 && odd_offset)) begin
          if (gather_cnt == 0) begin
            gather     = {24'd0, b};
            gather_cnt = 2'd1;
          end else begin
            tag = {gather[7:0], b};
            case (tag[15:12])
              TAG_D4:  blk = BT_D4;
              TAG_D8:  blk = BT_D8;
              TAG_D12: blk = BT_D12;
              TAG_D16: blk = BT_D16;
              default: blk = BT_ABS;
            endcase
            blk_left   = tag[7:0];
            gather_cnt = '0;
            gather     = '0;
            if (blk_left == 0)
              close_block();
            else
              phase = PH_DATA;
          end
        end
      end else begin
        case (blk)
          BT_D4: begin
            apply_diff(sext({28'd0, b[7:4]}, 4));
            if (blk_left != 0)
              apply_diff(sext({28'd0, b[3:0]}, 4));
          end
          BT_D8: apply_diff(sext({24'd0, b}, 8));
          BT_D12: begin
            if (gather_cnt == 0) begin
              gather     = {24'd0, b};
              gather_cnt = 2'd1;
            end else if (gather_cnt == 2'd1) begin
              apply_diff(sext({20'd0, gather[7:0], b[7:4]}, 12));
              gather     = {28'd0, b[3:0]};
              gather_cnt = (blk_left != 0) ? 2'd2 : 2'd0;
            end else begin
              apply_diff(sext({20'd0, gather[3:0], b}, 12));
              gather_cnt = '0;
            end
          end
          BT_D16: begin
            if (gather_cnt == 0) begin
              gather     = {24'd0, b};
              gather_cnt = 2'd1;
            end else begin
              apply_diff(sext({16'd0, gather[7:0], b}, 16));
              gather_cnt = '0;
            end
          end
          default: begin
            gather = {gather[23:0], b};
            if (gather_cnt == 2'd2) begin
              running = sext(gather, 24);
              if (blk_left != 0)
                blk_left--;
              add_sample(running);
              gather_cnt = '0;
            end else begin
              gather_cnt++;
            end
          end
        endcase
        if (blk_left == 0)
          close_block();
      end
      odd_offset = ~odd_offset;
      for (int i = 0; i < beat_cnt; i++) begin
        beat_buf[i].run_last = (i == beat_cnt - 1);
        pending_samples.push_back(beat_buf[i]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_samples.size() == 0) begin
          $error("sample beat with none expected: value %0d channel %0d",
                 out_bus.sample_value, out_bus.channel_index);
          mismatches++;
        end else begin
          want_beat = pending_samples.pop_front();
          if (out_bus.sample_value !== want_beat.sample_value) begin
            $error("sample_value: expected %0d, got %0d",
                   want_beat.sample_value, out_bus.sample_value);
            mismatches++;
          end
          if (out_bus.channel_index !== want_beat.channel_index) begin
            $error("channel_index: expected %0d, got %0d",
                   want_beat.channel_index, out_bus.channel_index);
            mismatches++;
          end
          if (out_bus.run_last !== want_beat.run_last) begin
            $error("run_last: expected %0d, got %0d", want_beat.run_last, out_bus.run_last);
            mismatches++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready)
        decode_byte(in_bus.data_byte, in_bus.packet_start);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : sink_pacing
    int stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 17);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.data_byte    <= b;
    in_bus.packet_start <= st;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [11:0] spc, input logic [11:0] cc_word);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_SAMPLES_PER_CHANNEL;
    cfg_wdata <= spc;
    @(negedge clk);
    cfg_addr  <= REG_CHANNEL_COUNT;
    cfg_wdata <= cc_word;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    spc_setting  = spc;
    chan_setting = cc_word[4:0];
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int block_bytes(input logic [3:0] nib, input int cnt);
    case (nib)
      TAG_D4:  return (cnt + 1) / 2;
      TAG_D8:  return cnt;
      TAG_D12: return (cnt / 2) * 3 + (cnt % 2) * 2;
      TAG_D16: return 2 * cnt;
      default: return 3 * cnt;
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b);
    if (pkt_off < pkt_cut) begin
      send_byte(b, pkt_off == 0);
      pkt_off++;
    end
  endtask

  task automatic send_packet(input int nch, input int spc, input int cut);
    int         emitted;
    int         cnt;
    logic [3:0] nib;
    pkt_off = 0;
    pkt_cut = cut;
    if (nch == 0)
      repeat ($urandom_range(1, 6)) put_byte(rand_byte());
    for (int c = 0; c < nch && pkt_off < pkt_cut; c++) begin
      if (pkt_off % 2 != 0)
        put_byte(rand_byte());
      repeat (4) put_byte(rand_byte());
      emitted = 1;
      while (emitted < spc && pkt_off < pkt_cut) begin
        if (pkt_off % 2 != 0)
          put_byte(rand_byte());
        case ($urandom_range(0, 7))
          0:       nib = TAG_D4;
          1:       nib = TAG_D8;
          2:       nib = TAG_D12;
          3:       nib = TAG_D16;
          4:       nib = 4'h0;
          5:       nib = 4'hf;
          default: nib = 4'($urandom_range(5, 14));
        endcase
        cnt = $urandom_range(0, 7);
        if (nib == TAG_D4 && $urandom_range(0, 15) == 0)
          cnt = $urandom_range(128, 255);
        put_byte({nib, 4'($urandom)});
        put_byte(8'(cnt));
        repeat (block_bytes(nib, cnt)) put_byte(rand_byte());
        emitted += cnt;
      end
    end
    repeat ($urandom_range(0, 2)) send_byte(rand_byte(), 1'b0);
  endtask

  task automatic test_opening_packet();
    send_byte(8'hff, 1'b0);
    for (int i = 0; i < $size(OPENING_PKT); i++)
      send_byte(OPENING_PKT[i], i == 0);
  endtask

  task automatic test_all_channels();
    wait_drained();
    write_config(12'd1, {7'h7f, 5'd31});
    send_packet(LANE_LIMIT, 1, NO_CUT);
    send_packet(LANE_LIMIT, 1, 30);
    send_packet(LANE_LIMIT, 1, NO_CUT);
  endtask

  task automatic test_degenerate_counts();
    wait_drained();
    write_config(12'd0, 12'd0);
    send_packet(0, 0, NO_CUT);
    wait_drained();
    write_config(12'd0, 12'd2);
    send_packet(2, 0, NO_CUT);
  endtask

  task automatic test_long_channel();
    wait_drained();
    write_config(COUNT_CEIL, 12'd16);
    send_packet(LANE_LIMIT, int'(COUNT_CEIL), 70);
    send_packet(LANE_LIMIT, int'(COUNT_CEIL), 40);
  endtask

  task automatic test_random_phases();
    int spc;
    int cc;
    int nch;
    int cut;
    int pkts;
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0:       spc = 0;
        1:       spc = int'(COUNT_CEIL);
        2:       spc = $urandom_range(9, 4094);
        default: spc = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       cc = 0;
        1:       cc = 16;
        2:       cc = $urandom_range(17, 31);
        default: cc = $urandom_range(1, 3);
      endcase
      write_config(12'(spc), {7'($urandom), 5'(cc)});
      nch     = (cc > LANE_LIMIT) ? LANE_LIMIT : cc;
      no_idle = ($urandom_range(0, 3) == 0);
      pkts    = (nch > 3) ? 1 : $urandom_range(2, 5);
      repeat (pkts) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30) : NO_CUT;
        if (spc > 8)
          cut = $urandom_range(20, 80);
        send_packet(nch, spc, cut);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_steady_stream();
    wait_drained();
    no_idle = 1'b1;
    write_config(12'd3, 12'd2);
    repeat (3) send_packet(2, 3, NO_CUT);
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_addr            = REG_SAMPLES_PER_CHANNEL;
    cfg_wdata           = '0;
    in_bus.valid        = 1'b0;
    in_bus.data_byte    = '0;
    in_bus.packet_start = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_opening_packet();
    test_all_channels();
    test_degenerate_counts();
    test_long_channel();
    test_random_phases();
    test_steady_stream();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
